// ===== rtl/tcrb_pkg.sv =====
// shared constants, command codes and types for the text console row buffer
package tcrb_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
  localparam int CELL_AW     = $clog2(CELL_COUNT);

  // widths of the payload fields
  localparam int CMD_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int COLUMN_W = 7;
  localparam int ROW_W    = 6;

  // effective size values reach the maxima themselves
  localparam int WIDTH_W  = 8;
  localparam int COUNT_W  = 7;

  localparam logic [CHAR_W-1:0] FILL_CHAR = 8'd65;
  localparam logic [CHAR_W-1:0] PAD_CHAR  = 8'd32;

  localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 8'd80;
  localparam logic [COUNT_W-1:0] LINE_COUNT_RESET = 7'd25;

  localparam logic [CMD_W-1:0] CMD_LINE_CHAR   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LINE_END    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PLACE_START = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PLACE_CHAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_CELL   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd5;

  // register index carried by paddr[2]
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_LINE_COUNT = 1'b1;

  typedef logic [CELL_AW-1:0] cell_addr_t;

  typedef struct packed {
    logic              en;
    cell_addr_t        addr;
    logic [CHAR_W-1:0] data;
  } cell_wr_t;

endpackage

// ===== rtl/tcrb_if.sv =====
// valid/ready channels for command beats and result beats
interface tcrb_req_if;
  import tcrb_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [CHAR_W-1:0]   ch;
  logic [COLUMN_W-1:0] column;
  logic [ROW_W-1:0]    row;

  modport source (output valid, command, ch, column, row, input ready);
  modport sink   (input valid, command, ch, column, row, output ready);
endinterface

interface tcrb_rsp_if;
  import tcrb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_value;
  logic [ROW_W-1:0]  cursor_row;
  logic              stored;

  modport source (output valid, cell_value, cursor_row, stored, input ready);
  modport sink   (input valid, cell_value, cursor_row, stored, output ready);
endinterface

// ===== rtl/text_console_row_buffer.sv =====
// top level of the text console row buffer: cursor control, sweeps and config port
//
//   channel  dir  handshake            payload
//   req      in   valid/ready          command, ch, column, row
//   rsp      out  valid/ready          cell_value, cursor_row, stored
//   apb      in   psel/penable/pready  paddr, pwdata, prdata (line_width, line_count)
//
// line char, place start, place char and unused codes go straight to the output register
// read cell goes through the registered memory read port, res_value and the output register
// line end with padding writes one pad cell per cycle up to the line width, then replies
// clear sweeps all CELL_COUNT (8192) cells, then replies; after reset the same sweep runs
// with req.ready low and no reply, config writes are taken throughout
// a result waiting in the output register does not block a new beat if rsp.ready is high
module text_console_row_buffer
  import tcrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tcrb_req_if.sink    req,
  tcrb_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_PAD    = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  localparam cell_addr_t LAST_ADDR = CELL_AW'(CELL_COUNT - 1);

  logic [2:0]          state;
  cell_addr_t          clr_addr;
  logic                clr_reply;

  // config registers
  logic [WIDTH_W-1:0]  line_width;
  logic [COUNT_W-1:0]  line_count;

  // cursors
  logic [ROW_W-1:0]    row_cursor;
  logic [COLUMN_W-1:0] line_column;
  logic                first_row;
  logic [WIDTH_W-1:0]  place_column;
  logic [ROW_W-1:0]    place_row;
  logic [WIDTH_W-1:0]  pad_col;
  logic                rd_hit;

  // pending result of a read cell, padded line end or clear beat
  logic [CHAR_W-1:0]   res_value;
  logic                res_stored;

  // output register
  logic                out_valid;
  logic [CHAR_W-1:0]   out_value;
  logic [ROW_W-1:0]    out_row;
  logic                out_stored;

  logic [WIDTH_W-1:0]  eff_w;
  logic [COUNT_W-1:0]  eff_h;
  logic                out_free;
  logic                accept;
  logic [COUNT_W-1:0]  row_inc;
  logic [ROW_W-1:0]    row_adv;
  logic [WIDTH_W-1:0]  col_inc;
  logic                place_ok;
  logic                pad_busy;
  logic [ROW_W-1:0]    sel_row;
  logic [WIDTH_W-1:0]  sel_col;
  logic [ROW_W+WIDTH_W-1:0] row_base;
  logic [ROW_W+WIDTH_W-1:0] cell_sum;
  cell_addr_t          cell_addr;
  cell_wr_t            wr;
  logic                rd_en;
  logic [CHAR_W-1:0]   rd_data;
  logic                cfg_wr;

  // registers out of range are clamped
  always_comb begin
    if (line_width == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (line_width > WIDTH_W'(MAX_COLUMNS)) begin
      eff_w = WIDTH_W'(MAX_COLUMNS);
    end else begin
      eff_w = line_width;
    end
    if (line_count == '0) begin
      eff_h = COUNT_W'(1);
    end else if (line_count > COUNT_W'(MAX_ROWS)) begin
      eff_h = COUNT_W'(MAX_ROWS);
    end else begin
      eff_h = line_count;
    end
  end

  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign accept = req.valid && req.ready;

  // row cursor advance wraps to row 0 at or past the row count
  assign row_inc = {1'b0, row_cursor} + COUNT_W'(1);
  assign row_adv = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
  assign col_inc = {1'b0, line_column} + WIDTH_W'(1);

  assign place_ok = (place_column < eff_w) && ({1'b0, place_row} < eff_h);
  assign pad_busy = pad_col < eff_w;

  // one shared row * width + column address path
  always_comb begin
    sel_row = row_cursor;
    sel_col = {1'b0, line_column};
    if (state == ST_PAD) begin
      sel_col = pad_col;
    end else begin
      case (req.command)
        CMD_PLACE_CHAR: begin
          sel_row = place_row;
          sel_col = place_column;
        end
        CMD_READ_CELL: begin
          sel_row = req.row;
          sel_col = {1'b0, req.column};
        end
        default: begin
          sel_row = row_cursor;
          sel_col = {1'b0, line_column};
        end
      endcase
    end
  end

  assign row_base  = (ROW_W + WIDTH_W)'(sel_row) * (ROW_W + WIDTH_W)'(eff_w);
  assign cell_sum  = row_base + (ROW_W + WIDTH_W)'(sel_col);
  assign cell_addr = cell_sum[CELL_AW-1:0];

  // cell writes: clear sweep, pad sweep or a character beat
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = cell_addr;
    wr.data = req.ch;
    if (state == ST_CLEAR) begin
      wr.en   = 1'b1;
      wr.addr = clr_addr;
      wr.data = FILL_CHAR;
    end else if (state == ST_PAD) begin
      wr.en   = pad_busy;
      wr.data = PAD_CHAR;
    end else if (accept) begin
      wr.en = (req.command == CMD_LINE_CHAR) ||
              ((req.command == CMD_PLACE_CHAR) && place_ok);
    end
  end

  assign rd_en = accept && (req.command == CMD_READ_CELL);

  tcrb_cell_ram u_cell_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (cell_addr),
    .rd_data (rd_data)
  );

  // config port, paddr[2] selects the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_LINE_COUNT) ? {25'd0, line_count} : {24'd0, line_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      line_count <= LINE_COUNT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LINE_WIDTH) begin
        line_width <= pwdata[WIDTH_W-1:0];
      end else begin
        line_count <= pwdata[COUNT_W-1:0];
      end
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      clr_reply    <= 1'b0;
      out_valid    <= 1'b0;
      row_cursor   <= '0;
      line_column  <= '0;
      first_row    <= 1'b1;
      place_column <= '0;
      place_row    <= '0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + CELL_AW'(1);
          if (clr_addr == LAST_ADDR) begin
            res_value  <= '0;
            res_stored <= 1'b0;
            state      <= clr_reply ? ST_FINISH : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            // beats that finish at once load the output register right away
            out_valid  <= 1'b1;
            out_value  <= '0;
            out_row    <= row_cursor;
            out_stored <= 1'b0;
            case (req.command)
              CMD_LINE_CHAR: begin
                out_stored <= 1'b1;
                if (col_inc >= eff_w) begin
                  line_column <= '0;
                  row_cursor  <= row_adv;
                  out_row     <= row_adv;
                  first_row   <= 1'b0;
                end else begin
                  line_column <= col_inc[COLUMN_W-1:0];
                end
              end
              CMD_LINE_END: begin
                line_column <= '0;
                first_row   <= 1'b1;
                // no padding when the line ended right on a wrapped row boundary
                if (first_row || (line_column != '0)) begin
                  out_valid <= 1'b0;
                  pad_col   <= {1'b0, line_column};
                  state     <= ST_PAD;
                end
              end
              CMD_PLACE_START: begin
                place_column <= {1'b0, req.column};
                place_row    <= req.row;
              end
              CMD_PLACE_CHAR: begin
                if (place_ok) begin
                  place_column <= place_column + WIDTH_W'(1);
                  out_stored   <= 1'b1;
                end
              end
              CMD_READ_CELL: begin
                out_valid <= 1'b0;
                rd_hit    <= ({1'b0, req.column} < eff_w) && ({1'b0, req.row} < eff_h);
                state     <= ST_READ;
              end
              CMD_CLEAR: begin
                out_valid   <= 1'b0;
                row_cursor  <= '0;
                line_column <= '0;
                first_row   <= 1'b1;
                clr_addr    <= '0;
                clr_reply   <= 1'b1;
                state       <= ST_CLEAR;
              end
              default: begin
                out_stored <= 1'b0;
              end
            endcase
          end
        end
        ST_PAD: begin
          if (pad_busy) begin
            pad_col <= pad_col + WIDTH_W'(1);
          end else begin
            row_cursor <= row_adv;
            res_value  <= '0;
            res_stored <= 1'b1;
            state      <= ST_FINISH;
          end
        end
        ST_READ: begin
          res_value  <= rd_hit ? rd_data : '0;
          res_stored <= 1'b0;
          state      <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_value  <= res_value;
            out_row    <= row_cursor;
            out_stored <= res_stored;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cell_value = out_value;
  assign rsp.cursor_row = out_row;
  assign rsp.stored     = out_stored;

endmodule

// ===== rtl/tcrb_cell_ram.sv =====
// character cell memory, one write port and one registered read port
module tcrb_cell_ram
  import tcrb_pkg::*;
(
  input  logic              clk,
  input  cell_wr_t          wr,
  input  logic              rd_en,
  input  cell_addr_t        rd_addr,
  output logic [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
